// ===== rtl/core/aes_cfb128_byte_decryptor_top_assert.svh =====
// Assertion macros for the CFB-128 byte decryptor top level.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef AES_CFB128_BYTE_DECRYPTOR_TOP_ASSERT_SVH
`define AES_CFB128_BYTE_DECRYPTOR_TOP_ASSERT_SVH

// same-cycle implication
`define ACFB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("acfb assertion failed");

// next-cycle implication
`define ACFB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("acfb assertion failed");

`endif

// ===== rtl/core/acfb_pkg.sv =====
// Shared types, constants and AES round functions for the CFB-128 decryptor.
// No dependencies.
package acfb_pkg;

  localparam int unsigned BLOCK_BYTES = 16;
  localparam logic [3:0] LAST_POS = 4'(BLOCK_BYTES - 1);

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_KEY0   = 3'd1;
  localparam logic [2:0] REG_KEY1   = 3'd2;
  localparam logic [2:0] REG_KEY2   = 3'd3;
  localparam logic [2:0] REG_KEY3   = 3'd4;
  localparam logic [2:0] REG_IV_UP  = 3'd5;
  localparam logic [2:0] REG_IV_LO  = 3'd6;

  localparam logic [1:0] MODE_128 = 2'd0;
  localparam logic [1:0] MODE_192 = 2'd1;

  typedef struct packed {
    logic         load;
    logic [1:0]   mode;
    logic [255:0] key;
    logic [127:0] iv;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] pos;
    logic [7:0] data;
  } head_t;

  typedef struct packed {
    logic         en;
    logic [3:0]   row;
    logic [127:0] data;
  } rk_wr_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xt(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // mode 3 saturates to AES-256
  function automatic logic [3:0] num_rounds(input logic [1:0] mode);
    logic [3:0] r;
    unique case (mode)
      MODE_128: r = 4'd10;
      MODE_192: r = 4'd12;
      default:  r = 4'd14;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] num_key_words(input logic [1:0] mode);
    return 4'(num_rounds(mode) - 4'd6);
  endfunction

  // SubBytes, ShiftRows and, unless last, MixColumns; byte 0 in the top bits
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [127:0] r;
    logic [7:0] a0, a1, a2, a3, al;
    int c, i;
    for (i = 0; i < 16; i++) b[i] = s[127 - 8*i -: 8];
    for (c = 0; c < 4; c++)
      for (i = 0; i < 4; i++)
        t[4*c + i] = SBOX[b[4*((c + i) & 3) + i]];
    for (c = 0; c < 4; c++) begin
      a0 = t[4*c];
      a1 = t[4*c + 1];
      a2 = t[4*c + 2];
      a3 = t[4*c + 3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (last) begin
        r[127 - 32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        r[127 - 32*c -: 32] = {a0 ^ al ^ xt(a0 ^ a1), a1 ^ al ^ xt(a1 ^ a2),
                               a2 ^ al ^ xt(a2 ^ a3), a3 ^ al ^ xt(a3 ^ a0)};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/acfb_regs.sv =====
// APB configuration registers: key length mode, cipher key and IV.
// Depends on acfb_pkg.
module acfb_regs import acfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [1:0]  mode;
  logic [63:0] key_w [4];
  logic [63:0] iv_up, iv_lo;
  logic        load;
  logic [2:0]  idx;
  logic        wr;

  assign idx    = paddr[5:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_128;
      key_w <= '{default: '0};
      iv_up <= '0;
      iv_lo <= '0;
      load  <= 1'b0;
    end else begin
      load <= wr && (idx <= REG_IV_LO);
      if (wr) begin
        unique case (idx)
          REG_MODE:  mode     <= pwdata[1:0];
          REG_KEY0:  key_w[0] <= pwdata;
          REG_KEY1:  key_w[1] <= pwdata;
          REG_KEY2:  key_w[2] <= pwdata;
          REG_KEY3:  key_w[3] <= pwdata;
          REG_IV_UP: iv_up    <= pwdata;
          REG_IV_LO: iv_lo    <= pwdata;
          default:   ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:  prdata = {62'd0, mode};
      REG_KEY0:  prdata = key_w[0];
      REG_KEY1:  prdata = key_w[1];
      REG_KEY2:  prdata = key_w[2];
      REG_KEY3:  prdata = key_w[3];
      REG_IV_UP: prdata = iv_up;
      REG_IV_LO: prdata = iv_lo;
      default:   prdata = '0;
    endcase
  end

  assign cfg.load = load;
  assign cfg.mode = mode;
  assign cfg.key  = {key_w[0], key_w[1], key_w[2], key_w[3]};
  assign cfg.iv   = {iv_up, iv_lo};

endmodule

// ===== rtl/core/acfb_keyexp.sv =====
// Key expansion: one 32-bit schedule word per cycle, written out a row at a time.
// Depends on acfb_pkg.
module acfb_keyexp import acfb_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  output logic   busy,
  output rk_wr_t rk_wr
);

  logic [31:0] win [8];
  logic [31:0] row_buf [3];
  logic [31:0] kw [8];
  logic [5:0]  i;
  logic [2:0]  k;
  logic [7:0]  rcon;
  logic [3:0]  nk;
  logic [2:0]  nkm1;
  logic [5:0]  last_i;
  logic [31:0] prev, back, w;

  assign nk     = num_key_words(cfg.mode);
  assign nkm1   = 3'(nk - 4'd1);
  assign last_i = {num_rounds(cfg.mode), 2'b11};
  assign prev   = win[0];
  assign back   = win[nkm1];

  always_comb begin
    for (int j = 0; j < 8; j++) kw[j] = cfg.key[255 - 32*j -: 32];
  end

  always_comb begin
    priority if (i < {2'b00, nk}) begin
      w = kw[i[2:0]];
    end else if (k == 3'd0) begin
      w = back ^ sub_word({prev[23:0], prev[31:24]}) ^ {rcon, 24'd0};
    end else if (nk == 4'd8 && k == 3'd4) begin
      w = back ^ sub_word(prev);
    end else begin
      w = back ^ prev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.load) begin
      busy <= 1'b1;
      i    <= '0;
      k    <= '0;
      rcon <= 8'h01;
    end else if (busy) begin
      i <= i + 6'd1;
      k <= (k == nkm1) ? 3'd0 : k + 3'd1;
      if (i >= {2'b00, nk} && k == 3'd0) rcon <= xt(rcon);
      if (i == last_i) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      win[0] <= w;
      for (int j = 1; j < 8; j++) win[j] <= win[j-1];
      if (i[1:0] != 2'b11) row_buf[i[1:0]] <= w;
    end
  end

  assign rk_wr.en   = busy && (i[1:0] == 2'b11);
  assign rk_wr.row  = i[5:2];
  assign rk_wr.data = {row_buf[0], row_buf[1], row_buf[2], w};

endmodule

// ===== rtl/core/acfb_front.sv =====
// Front end: accepts ciphertext bytes, tags each with its block position, queues them.
// Depends on acfb_pkg.
module acfb_front import acfb_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_load,
  input  logic       in_push,
  input  logic [7:0] in_data,
  output logic       q_full,
  output head_t      head,
  input  logic       head_pop
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [7:0]    q_data [DEPTH];
  logic [3:0]    q_pos  [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic [3:0]    pos;
  logic          do_push, do_pop;

  assign q_full  = (count == CW'(DEPTH));
  assign do_push = in_push && !q_full;
  assign do_pop  = head_pop && (count != '0);

  always_ff @(posedge clk) begin
    if (rst || cfg_load) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      pos    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
        pos    <= pos + 4'd1;
      end
      if (do_pop) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (do_push && !do_pop) count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_data[wr_ptr] <= in_data;
      q_pos[wr_ptr]  <= pos;
    end
  end

  assign head.valid = (count != '0);
  assign head.pos   = q_pos[rd_ptr];
  assign head.data  = q_data[rd_ptr];

endmodule

// ===== rtl/core/acfb_back.sv =====
// Back end: iterative AES round engine on the feedback block, round key memory,
// byte decryption and result queue. Depends on acfb_pkg.
module acfb_back import acfb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       kx_busy,
  input  rk_wr_t     rk_wr,
  input  head_t      head,
  output logic       head_pop,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] plain_byte
);

  logic [127:0] rk_mem [15];
  logic [127:0] rk_q;
  logic [127:0] fb;
  logic [3:0]   rd_addr, rnd, nr;
  logic         running, ks_ready;
  logic         start;
  logic [6:0]   bitpos;
  logic [7:0]   plain;
  logic [7:0]   oq_data [2];
  logic         oq_wr, oq_rd;
  logic [1:0]   oq_cnt;
  logic         do_pop;

  assign nr       = num_rounds(cfg.mode);
  assign start    = head.valid && !ks_ready && !running && !kx_busy;
  assign head_pop = head.valid && ks_ready && (oq_cnt != 2'd2);
  assign rd_addr  = (running && rnd != nr) ? rnd + 4'd1 : 4'd0;
  assign bitpos   = 7'(7'd120 - {head.pos, 3'b000});
  assign plain    = fb[bitpos +: 8] ^ head.data;

  always_ff @(posedge clk) begin
    if (rk_wr.en) rk_mem[rk_wr.row] <= rk_wr.data;
    rk_q <= rk_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fb       <= '0;
      running  <= 1'b0;
      ks_ready <= 1'b0;
      rnd      <= '0;
    end else if (cfg.load) begin
      fb       <= cfg.iv;
      running  <= 1'b0;
      ks_ready <= 1'b0;
    end else begin
      if (start) begin
        running <= 1'b1;
        rnd     <= '0;
      end
      if (running) begin
        fb  <= ((rnd == 4'd0) ? fb : aes_round(fb, rnd == nr)) ^ rk_q;
        rnd <= rnd + 4'd1;
        if (rnd == nr) begin
          running  <= 1'b0;
          ks_ready <= 1'b1;
        end
      end
      if (head_pop) begin
        fb[bitpos +: 8] <= head.data;
        if (head.pos == LAST_POS) ks_ready <= 1'b0;
      end
    end
  end

  assign do_pop = pop && !empty;
  assign empty  = (oq_cnt == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr  <= 1'b0;
      oq_rd  <= 1'b0;
      oq_cnt <= '0;
    end else begin
      if (head_pop) oq_wr <= !oq_wr;
      if (do_pop) oq_rd <= !oq_rd;
      if (head_pop && !do_pop) oq_cnt <= oq_cnt + 2'd1;
      else if (do_pop && !head_pop) oq_cnt <= oq_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) oq_data[oq_wr] <= plain;
  end

  assign plain_byte = oq_data[oq_rd];

endmodule

// ===== rtl/core/aes_cfb128_byte_decryptor_top.sv =====
// AES CFB-128 byte decryptor. Byte at block position 0 waits for the block
// encryption by the one-round-per-cycle engine. Other bytes go from the input queue
// to the result queue whenever the result queue has room. After reset and after each
// write to REG_MODE through REG_IV_LO, full stays high during key expansion.
`include "aes_cfb128_byte_decryptor_top_assert.svh"
module aes_cfb128_byte_decryptor_top import acfb_pkg::*; #(
  parameter int unsigned IN_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  cipher_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  plain_byte
);

  cfg_t   cfg;
  rk_wr_t rk_wr;
  head_t  head;
  logic   kx_busy, q_full, head_pop;

  assign full = q_full || kx_busy || cfg.load;

  acfb_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  acfb_keyexp u_keyexp (
    .clk, .rst, .cfg, .busy(kx_busy), .rk_wr
  );

  acfb_front #(.DEPTH(IN_DEPTH)) u_front (
    .clk, .rst, .cfg_load(cfg.load), .in_push(push && !full), .in_data(cipher_byte),
    .q_full, .head, .head_pop
  );

  acfb_back u_back (
    .clk, .rst, .cfg, .kx_busy, .rk_wr, .head, .head_pop, .pop, .empty, .plain_byte
  );

  `ACFB_ASSERT_IMP(a_busy_full, kx_busy, full)
  `ACFB_ASSERT_NEXT(a_load_busy, cfg.load, kx_busy)
  `ACFB_ASSERT_IMP(a_no_pop_busy, head_pop, !kx_busy)

endmodule

// ===== bench/cfb_decrypt_checker.sv =====
// Checker for the CFB-128 byte decryptor: mirrors register writes, predicts each
// plaintext byte and compares it with the byte popped from the block.
// Depends on acfb_pkg for the S-box and register index constants.
module cfb_decrypt_checker import acfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  cipher_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  plain_byte,
  output int          mismatches,
  output int          outstanding
);

  logic [1:0]  mode_reg;
  logic [63:0] key_reg [4];
  logic [63:0] iv_hi, iv_lo;
  logic [7:0]  shift_reg [16];
  logic [3:0]  position;
  logic [7:0]  sched [15][16];
  int          rounds;
  logic [7:0]  plain_q [$];

  function automatic logic [7:0] dbl(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  task automatic expand_schedule();
    logic [7:0] w [60][4];
    logic [7:0] t [4];
    logic [7:0] r, rc;
    int nk, total, i, j, m;
    m = (mode_reg == 2'd3) ? 2 : int'(mode_reg);
    nk = 4 + 2 * m;
    rounds = nk + 6;
    total = 4 * (rounds + 1);
    rc = 8'h01;
    for (i = 0; i < nk; i++)
      for (j = 0; j < 4; j++)
        w[i][j] = key_reg[(4*i + j) / 8][63 - 8*((4*i + j) % 8) -: 8];
    for (i = nk; i < total; i++) begin
      for (j = 0; j < 4; j++) t[j] = w[i-1][j];
      if (i % nk == 0) begin
        r = t[0];
        t[0] = SBOX[t[1]] ^ rc;
        t[1] = SBOX[t[2]];
        t[2] = SBOX[t[3]];
        t[3] = SBOX[r];
        rc = dbl(rc);
      end else if (nk > 6 && i % nk == 4) begin
        for (j = 0; j < 4; j++) t[j] = SBOX[t[j]];
      end
      for (j = 0; j < 4; j++) w[i][j] = w[i-nk][j] ^ t[j];
    end
    for (i = 0; i < 15; i++)
      for (j = 0; j < 16; j++)
        sched[i][j] = (4*i + j/4 < total) ? w[4*i + j/4][j%4] : 8'h00;
    for (i = 0; i < 8; i++) begin
      shift_reg[i]     = iv_hi[63 - 8*i -: 8];
      shift_reg[8 + i] = iv_lo[63 - 8*i -: 8];
    end
    position = 4'd0;
  endtask

  task automatic encrypt_shift_reg();
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    int r, c, i;
    for (i = 0; i < 16; i++) shift_reg[i] ^= sched[0][i];
    for (r = 1; r <= rounds; r++) begin
      for (c = 0; c < 4; c++)
        for (i = 0; i < 4; i++)
          t[4*c + i] = SBOX[shift_reg[4*((c + i) & 3) + i]];
      for (c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        if (r == rounds) begin
          shift_reg[4*c] = a0; shift_reg[4*c+1] = a1;
          shift_reg[4*c+2] = a2; shift_reg[4*c+3] = a3;
        end else begin
          shift_reg[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
          shift_reg[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
          shift_reg[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
          shift_reg[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
        end
      end
      for (i = 0; i < 16; i++) shift_reg[i] ^= sched[r][i];
    end
  endtask

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("mismatch at %0t: %s got %02h want %02h", $realtime, what, got, want);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    outstanding = 0;
    mode_reg = 2'd0;
    for (int k = 0; k < 4; k++) key_reg[k] = 64'd0;
    iv_hi = 64'd0;
    iv_lo = 64'd0;
    expand_schedule();
  end

  always @(posedge clk) begin
    logic [7:0] want;
    int idx;
    if (!rst) begin
      if (psel && penable && pwrite && pready) begin
        idx = int'(paddr) / 8;
        if (idx <= int'(REG_IV_LO)) begin
          if (idx == int'(REG_MODE)) mode_reg = pwdata[1:0];
          else if (idx <= int'(REG_KEY3)) key_reg[idx - 1] = pwdata;
          else if (idx == int'(REG_IV_UP)) iv_hi = pwdata;
          else iv_lo = pwdata;
          expand_schedule();
        end
      end
      if (push && !full) begin
        if (position == 4'd0) encrypt_shift_reg();
        plain_q.push_back(shift_reg[position] ^ cipher_byte);
        shift_reg[position] = cipher_byte;
        position = position + 4'd1;
      end
      if (pop && !empty) begin
        if (plain_q.size() == 0) begin
          report("unexpected transaction", plain_byte, 8'h00);
        end else begin
          want = plain_q.pop_front();
          if (plain_byte !== want) report("plain_byte", plain_byte, want);
        end
      end
    end
    outstanding = plain_q.size();
  end

endmodule

// ===== bench/aes_cfb128_byte_decryptor_top_test.sv =====
// Testbench top for the CFB-128 byte decryptor: clock, reset, register writes,
// byte stimulus and the verdict. Depends on acfb_pkg, aes_cfb128_byte_decryptor_top and cfb_decrypt_checker.
module aes_cfb128_byte_decryptor_top_test import acfb_pkg::*;;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  cipher_byte = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  plain_byte;
  int          mismatches, outstanding;
  int          send_idle = 0, recv_idle = 0, hold_left = 0, quiet = 0;

  localparam int QUIET_LIMIT = 5000;

  always #4 clk = ~clk;

  aes_cfb128_byte_decryptor_top dut (.*);

  cfb_decrypt_checker chk (.*);

  always @(negedge clk) begin
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || psel || rst) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("aes_cfb128_byte_decryptor_top_test failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 6'(idx) << 3; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    cipher_byte <= b;
    do @(posedge clk); while (full);
  endtask

  task automatic stop_push();
    @(negedge clk);
    push <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_setting();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) begin
      case ($urandom_range(6))
        0: write_reg(REG_MODE, 64'($urandom_range(3)));
        1: write_reg(REG_KEY0, rand64());
        2: write_reg(REG_KEY1, rand64());
        3: write_reg(REG_KEY2, rand64());
        4: write_reg(REG_KEY3, rand64());
        5: write_reg(REG_IV_UP, rand64());
        default: write_reg(REG_IV_LO, rand64());
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_byte(8'h00); send_byte(8'hff); send_byte(8'h55); send_byte(8'haa);
    for (int k = 0; k < 14; k++) send_byte(8'(1 << (k % 8)));
    stop_push();
    wait_drained();

    write_reg(REG_MODE, 64'(MODE_192));
    write_reg(REG_KEY0, '1); write_reg(REG_KEY1, '1); write_reg(REG_KEY2, '1);
    write_reg(REG_KEY3, '1); write_reg(REG_IV_UP, '1); write_reg(REG_IV_LO, '1);
    write_reg(3'd7, rand64());
    for (int k = 0; k < 18; k++) send_byte(8'($urandom_range(255)));
    stop_push();
    wait_drained();
    write_reg(REG_MODE, 64'd3);
    for (int k = 0; k < 17; k++) send_byte(8'($urandom_range(255)));
    stop_push();
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 12 : (ph == 1) ? 49 : 0;
      recv_idle = (ph == 0) ? 49 : (ph == 1) ? 12 : 0;
      for (int s = 0; s < 6; s++) begin
        if (ph == 0 && s == 0) write_reg(REG_MODE, 64'd2);
        else if (ph == 1 && s == 0) write_reg(REG_MODE, 64'(MODE_128));
        else random_setting();
        if (ph == 2 && s == 2) hold_left = 300;
        repeat ($urandom_range(60, 110)) send_byte(8'($urandom_range(255)));
        stop_push();
        wait_drained();
      end
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("aes_cfb128_byte_decryptor_top_test passed");
    end else begin
      $display("aes_cfb128_byte_decryptor_top_test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/acfb_pkg.sv
rtl/core/acfb_regs.sv
rtl/core/acfb_keyexp.sv
rtl/core/acfb_front.sv
rtl/core/acfb_back.sv
rtl/core/aes_cfb128_byte_decryptor_top.sv
bench/cfb_decrypt_checker.sv
bench/aes_cfb128_byte_decryptor_top_test.sv
